// ===== src/core_language_lexer_unit_defines.svh =====
// Assertion macros shared by the lexer RTL files.
`ifndef CORE_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`define CORE_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lexer check failed");
`define CLL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lexer check failed");
`else
`define CLL_ASSERT_IMPLY(label, ante, cons)
`define CLL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/cll_pkg.sv =====
// Token codes and shared types of the lexer.
`default_nettype none
package cll_pkg;

   // Entries of the token queue; keep a power of two, at least two.
   localparam int unsigned TOKEN_FIFO_DEPTH = 4;

   localparam logic [5:0] TOK_ERROR     = 6'd0;
   localparam logic [5:0] TOK_PROGRAM   = 6'd1;
   localparam logic [5:0] TOK_BEGIN     = 6'd2;
   localparam logic [5:0] TOK_END       = 6'd3;
   localparam logic [5:0] TOK_INT       = 6'd4;
   localparam logic [5:0] TOK_IF        = 6'd5;
   localparam logic [5:0] TOK_THEN      = 6'd6;
   localparam logic [5:0] TOK_ELSE      = 6'd7;
   localparam logic [5:0] TOK_WHILE     = 6'd8;
   localparam logic [5:0] TOK_LOOP      = 6'd9;
   localparam logic [5:0] TOK_READ      = 6'd10;
   localparam logic [5:0] TOK_WRITE     = 6'd11;
   localparam logic [5:0] TOK_SEMI      = 6'd12;
   localparam logic [5:0] TOK_COMMA     = 6'd13;
   localparam logic [5:0] TOK_ASSIGN    = 6'd14;
   localparam logic [5:0] TOK_NOT       = 6'd15;
   localparam logic [5:0] TOK_LBRACKET  = 6'd16;
   localparam logic [5:0] TOK_RBRACKET  = 6'd17;
   localparam logic [5:0] TOK_AND       = 6'd18;
   localparam logic [5:0] TOK_OR        = 6'd19;
   localparam logic [5:0] TOK_LPAREN    = 6'd20;
   localparam logic [5:0] TOK_RPAREN    = 6'd21;
   localparam logic [5:0] TOK_PLUS      = 6'd22;
   localparam logic [5:0] TOK_MINUS     = 6'd23;
   localparam logic [5:0] TOK_TIMES     = 6'd24;
   localparam logic [5:0] TOK_NOT_EQUAL = 6'd25;
   localparam logic [5:0] TOK_EQUAL     = 6'd26;
   localparam logic [5:0] TOK_LESS      = 6'd27;
   localparam logic [5:0] TOK_GREATER   = 6'd28;
   localparam logic [5:0] TOK_LESS_EQ   = 6'd29;
   localparam logic [5:0] TOK_GREATER_EQ = 6'd30;
   localparam logic [5:0] TOK_INTEGER   = 6'd31;
   localparam logic [5:0] TOK_IDENT     = 6'd32;
   localparam logic [5:0] TOK_EOF       = 6'd33;

   typedef struct packed {
      logic [5:0] code;
      logic       last;
   } token_type;

   // Tokens produced by one input beat, in order; count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

endpackage
`default_nettype wire

// ===== src/cll_scanner.sv =====
// Lexer state machine: turns one source byte per beat into up to two tokens.
`default_nettype none
`include "core_language_lexer_unit_defines.svh"
module cll_scanner
   import cll_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_input,
   output push_type        push
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_KEYWORD,
      MODE_ID_LET,
      MODE_ID_DIG,
      MODE_INTEGER,
      MODE_GARBAGE,
      MODE_EQ,
      MODE_BANG,
      MODE_LT,
      MODE_GT,
      MODE_AMP,
      MODE_BAR
   } mode_type;

   typedef enum logic [2:0] {
      CLASS_OTHER,
      CLASS_DIGIT,
      CLASS_UPPER,
      CLASS_LOWER,
      CLASS_BLANK,
      CLASS_SYMBOL
   } byte_class_type;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] kw;
      logic [2:0] pos;
      logic       emit;
      logic [5:0] code;
   } start_type;

   mode_type   mode_ff, mode_in;
   logic [3:0] kw_ff, kw_in;
   logic [2:0] pos_ff, pos_in;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      if (b >= "0" && b <= "9") c = CLASS_DIGIT;
      else if (b >= "A" && b <= "Z") c = CLASS_UPPER;
      else if (b >= "a" && b <= "z") c = CLASS_LOWER;
      else if (b == " " || b == 8'h09 || b == 8'h0a) c = CLASS_BLANK;
      else if (b == "!" || (b >= "(" && b <= "-") || (b >= ";" && b <= ">") ||
               b == "[" || b == "]" || b == "|") c = CLASS_SYMBOL;
      else c = CLASS_OTHER;
      return c;
   endfunction

   function automatic logic [2:0] kw_len(input logic [3:0] k);
      logic [2:0] len;
      unique case (k)
         TOK_PROGRAM[3:0]: len = 3'd7;
         TOK_BEGIN[3:0]:   len = 3'd5;
         TOK_END[3:0]:     len = 3'd3;
         TOK_INT[3:0]:     len = 3'd3;
         TOK_IF[3:0]:      len = 3'd2;
         TOK_THEN[3:0]:    len = 3'd4;
         TOK_ELSE[3:0]:    len = 3'd4;
         TOK_WHILE[3:0]:   len = 3'd5;
         TOK_LOOP[3:0]:    len = 3'd4;
         TOK_READ[3:0]:    len = 3'd4;
         TOK_WRITE[3:0]:   len = 3'd5;
         default:          len = 3'd0;
      endcase
      return len;
   endfunction

   // Letter p of keyword k; words are left-justified in seven bytes.
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
      logic [55:0] word;
      logic [55:0] shifted;
      unique case (k)
         TOK_PROGRAM[3:0]: word = "program";
         TOK_BEGIN[3:0]:   word = {"begin", 16'h0000};
         TOK_END[3:0]:     word = {"end", 32'h0000_0000};
         TOK_INT[3:0]:     word = {"int", 32'h0000_0000};
         TOK_IF[3:0]:      word = {"if", 40'h00_0000_0000};
         TOK_THEN[3:0]:    word = {"then", 24'h00_0000};
         TOK_ELSE[3:0]:    word = {"else", 24'h00_0000};
         TOK_WHILE[3:0]:   word = {"while", 16'h0000};
         TOK_LOOP[3:0]:    word = {"loop", 24'h00_0000};
         TOK_READ[3:0]:    word = {"read", 24'h00_0000};
         TOK_WRITE[3:0]:   word = {"write", 16'h0000};
         default:          word = 56'd0;
      endcase
      shifted = word << {p, 3'b000};
      return shifted[55:48];
   endfunction

   // Open a new token on byte b, from the idle state or after a word closes.
   function automatic start_type start_token(input logic [7:0] b);
      start_type      s;
      byte_class_type c;
      c = classify(b);
      s.mode = MODE_IDLE;
      s.kw   = 4'd0;
      s.pos  = 3'd0;
      s.emit = 1'b0;
      s.code = TOK_ERROR;
      if (b > 8'd32 && b < 8'd128) begin
         case (b)
            "p": s.kw = TOK_PROGRAM[3:0];
            "b": s.kw = TOK_BEGIN[3:0];
            "e": s.kw = TOK_END[3:0];
            "i": s.kw = TOK_IF[3:0];
            "t": s.kw = TOK_THEN[3:0];
            "w": s.kw = TOK_WHILE[3:0];
            "l": s.kw = TOK_LOOP[3:0];
            "r": s.kw = TOK_READ[3:0];
            default: s.kw = 4'd0;
         endcase
         case (b)
            ";": begin s.emit = 1'b1; s.code = TOK_SEMI; end
            ",": begin s.emit = 1'b1; s.code = TOK_COMMA; end
            "[": begin s.emit = 1'b1; s.code = TOK_LBRACKET; end
            "]": begin s.emit = 1'b1; s.code = TOK_RBRACKET; end
            "(": begin s.emit = 1'b1; s.code = TOK_LPAREN; end
            ")": begin s.emit = 1'b1; s.code = TOK_RPAREN; end
            "+": begin s.emit = 1'b1; s.code = TOK_PLUS; end
            "-": begin s.emit = 1'b1; s.code = TOK_MINUS; end
            "*": begin s.emit = 1'b1; s.code = TOK_TIMES; end
            "=": s.mode = MODE_EQ;
            "!": s.mode = MODE_BANG;
            "<": s.mode = MODE_LT;
            ">": s.mode = MODE_GT;
            "&": s.mode = MODE_AMP;
            "|": s.mode = MODE_BAR;
            default: begin
               if (s.kw != 4'd0) begin
                  s.mode = MODE_KEYWORD;
                  s.pos  = 3'd1;
               end else if (c == CLASS_UPPER) begin
                  s.mode = MODE_ID_LET;
               end else if (c == CLASS_DIGIT) begin
                  s.mode = MODE_INTEGER;
               end else begin
                  s.mode = MODE_GARBAGE;
               end
            end
         endcase
      end
      return s;
   endfunction

   byte_class_type cls;
   start_type      st;
   logic [1:0]     n;
   logic [5:0]     code0, code1;
   logic           go_garbage;
   logic           word_done;
   logic [5:0]     word_code;
   logic [2:0]     len;
   logic           boundary;

   always_comb begin
      cls      = classify(data_byte);
      st       = start_token(data_byte);
      len      = kw_len(kw_ff);
      boundary = (cls == CLASS_BLANK) || (cls == CLASS_SYMBOL);
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      pos_in   = pos_ff;
      n        = 2'd0;
      code0    = TOK_ERROR;
      code1    = TOK_ERROR;
      go_garbage = 1'b0;
      word_done  = 1'b0;
      word_code  = TOK_ERROR;
      if (end_of_input) begin
         // flush the pending token, then mark the end
         unique case (mode_ff)
            MODE_IDLE: begin n = 2'd1; code0 = TOK_EOF; end
            MODE_EQ:   begin n = 2'd2; code0 = TOK_ASSIGN;  code1 = TOK_EOF; end
            MODE_BANG: begin n = 2'd2; code0 = TOK_NOT;     code1 = TOK_EOF; end
            MODE_LT:   begin n = 2'd2; code0 = TOK_LESS;    code1 = TOK_EOF; end
            MODE_GT:   begin n = 2'd2; code0 = TOK_GREATER; code1 = TOK_EOF; end
            default:   begin n = 2'd2; code0 = TOK_ERROR;   code1 = TOK_EOF; end
         endcase
         mode_in = MODE_IDLE;
         kw_in   = 4'd0;
         pos_in  = 3'd0;
      end else begin
         unique case (mode_ff)
            MODE_KEYWORD: begin
               priority if (kw_ff == 4'd0 || kw_ff > TOK_WRITE[3:0]) begin
                  go_garbage = 1'b1;
               end else if (pos_ff < len && kw_char(kw_ff, pos_ff) == data_byte) begin
                  pos_in = pos_ff + 3'd1;
               end else if (pos_ff == 3'd1 &&
                            ((kw_ff == TOK_END[3:0] && data_byte == "l") ||
                             (kw_ff == TOK_IF[3:0] && data_byte == "n") ||
                             (kw_ff == TOK_WHILE[3:0] && data_byte == "r"))) begin
                  // else / int / write share a first letter with end / if / while
                  if (kw_ff == TOK_END[3:0]) kw_in = TOK_ELSE[3:0];
                  else if (kw_ff == TOK_IF[3:0]) kw_in = TOK_INT[3:0];
                  else kw_in = TOK_WRITE[3:0];
                  pos_in = 3'd2;
               end else if (pos_ff == len && boundary) begin
                  word_done = 1'b1;
                  word_code = {2'b00, kw_ff};
               end else begin
                  go_garbage = 1'b1;
               end
            end
            MODE_ID_LET: begin
               if (cls == CLASS_DIGIT) mode_in = MODE_ID_DIG;
               else if (cls != CLASS_UPPER) begin
                  word_done  = boundary;
                  go_garbage = !boundary;
                  word_code  = TOK_IDENT;
               end
            end
            MODE_ID_DIG: begin
               if (cls != CLASS_DIGIT) begin
                  word_done  = boundary;
                  go_garbage = !boundary;
                  word_code  = TOK_IDENT;
               end
            end
            MODE_INTEGER: begin
               if (cls != CLASS_DIGIT) begin
                  word_done  = boundary;
                  go_garbage = !boundary;
                  word_code  = TOK_INTEGER;
               end
            end
            MODE_GARBAGE: go_garbage = 1'b1;
            MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
               if (data_byte == "=") begin
                  n = 2'd1;
                  unique case (mode_ff)
                     MODE_EQ:   code0 = TOK_EQUAL;
                     MODE_BANG: code0 = TOK_NOT_EQUAL;
                     MODE_LT:   code0 = TOK_LESS_EQ;
                     default:   code0 = TOK_GREATER_EQ;
                  endcase
                  mode_in = MODE_IDLE;
                  kw_in   = 4'd0;
                  pos_in  = 3'd0;
               end else begin
                  word_done = 1'b1;
                  unique case (mode_ff)
                     MODE_EQ:   word_code = TOK_ASSIGN;
                     MODE_BANG: word_code = TOK_NOT;
                     MODE_LT:   word_code = TOK_LESS;
                     default:   word_code = TOK_GREATER;
                  endcase
               end
            end
            MODE_AMP, MODE_BAR: begin
               // the byte after & or | is never tested for a blank
               if ((mode_ff == MODE_AMP && data_byte == "&") ||
                   (mode_ff == MODE_BAR && data_byte == "|")) begin
                  n       = 2'd1;
                  code0   = (mode_ff == MODE_AMP) ? TOK_AND : TOK_OR;
                  mode_in = MODE_IDLE;
                  kw_in   = 4'd0;
                  pos_in  = 3'd0;
               end else begin
                  mode_in = MODE_GARBAGE;
               end
            end
            default: begin
               n       = st.emit ? 2'd1 : 2'd0;
               code0   = st.code;
               mode_in = st.mode;
               kw_in   = st.kw;
               pos_in  = st.pos;
            end
         endcase
         if (go_garbage) begin
            mode_in = MODE_GARBAGE;
            if (cls == CLASS_BLANK) begin
               n       = 2'd1;
               code0   = TOK_ERROR;
               mode_in = MODE_IDLE;
               kw_in   = 4'd0;
               pos_in  = 3'd0;
            end
         end
         if (word_done) begin
            // close the word, then let the same byte open the next token
            n       = st.emit ? 2'd2 : 2'd1;
            code0   = word_code;
            code1   = st.code;
            mode_in = st.mode;
            kw_in   = st.kw;
            pos_in  = st.pos;
         end
      end
   end

   always_comb begin
      push.count       = accept ? n : 2'd0;
      push.first.code  = code0;
      push.first.last  = (n == 2'd1);
      push.second.code = code1;
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         kw_ff   <= 4'd0;
         pos_ff  <= 3'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kw_ff   <= kw_in;
         pos_ff  <= pos_in;
      end
   end

   `CLL_ASSERT_NEXT(eof_returns_idle, accept && end_of_input, mode_ff == MODE_IDLE)
   `CLL_ASSERT_IMPLY(eof_ends_with_eof_token, accept && end_of_input,
      (push.count == 2'd1 && push.first.code == TOK_EOF) ||
      (push.count == 2'd2 && push.second.code == TOK_EOF))
   `CLL_ASSERT_IMPLY(keyword_has_candidate, mode_ff == MODE_KEYWORD,
      kw_ff != 4'd0 && pos_ff != 3'd0)

endmodule
`default_nettype wire

// ===== src/cll_token_fifo.sv =====
// Token queue: takes up to two tokens per cycle, hands out one per beat.
`default_nettype none
`include "core_language_lexer_unit_defines.svh"
module cll_token_fifo
   import cll_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      push_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   output token_type out_token
);

   localparam int unsigned PtrWidth   = $clog2(TOKEN_FIFO_DEPTH);
   localparam int unsigned CountWidth = $clog2(TOKEN_FIFO_DEPTH + 1);

   token_type             tok_ff [TOKEN_FIFO_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  pop;

   // room for the worst case of two tokens from the next beat
   assign push_ready = count_ff <= CountWidth'(TOKEN_FIFO_DEPTH - 2);
   assign out_valid  = count_ff != '0;
   assign out_token  = tok_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      count_in  = count_ff + CountWidth'(push.count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) tok_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) tok_ff[wr_ptr_ff + PtrWidth'(1)] <= push.second;
   end

   `CLL_ASSERT_IMPLY(count_in_range, 1'b1, count_ff <= CountWidth'(TOKEN_FIFO_DEPTH))
   `CLL_ASSERT_IMPLY(push_only_with_room, push.count != 2'd0, push_ready)
   `CLL_ASSERT_NEXT(pop_drains_one, pop && push.count == 2'd0,
      count_ff == $past(count_ff) - CountWidth'(1))

endmodule
`default_nettype wire

// ===== src/core_language_lexer_unit.sv =====
// Top level of the streaming lexer: byte stream in, token code stream out.
//
// One source byte (or an end-of-input beat, req_tlast high) is taken per
// cycle; its tokens are decided in that same cycle by the scanner state
// machine and go into the token queue, which hands them to rsp one token
// per beat, with rsp_tlast on the last token a byte caused. A byte causes
// zero, one or two tokens, so the sustained rate is one byte per cycle while
// the output takes one token per cycle and averages at most one token per
// byte; the four-entry token queue sets the figure otherwise: req_tready
// falls while fewer than two entries are free, so two-token bytes stall the
// source. Skipped bytes and bytes inside a token give no beat.
`default_nettype none
module core_language_lexer_unit
   import cll_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_input
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [5:0] token_code, [7:6] zero
   output logic            rsp_tlast    // last_of_run
);

   push_type  push;
   token_type head;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   cll_scanner u_scanner (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .push         (push)
   );

   cll_token_fifo u_token_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_token  (head)
   );

   assign rsp_tdata = {2'b00, head.code};
   assign rsp_tlast = head.last;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the streaming lexer: byte beats in, token beats checked.
`timescale 1ns / 100ps
module tb_top;
   import cll_pkg::*;

   localparam int ITEM_TARGET     = 1824;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 500;
   localparam int DRAIN_AT        = 1200;
   localparam int SETTLE_CYCLES   = 16;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_KEYWORD, SCAN_ID_LETTERS, SCAN_ID_DIGITS, SCAN_INTEGER,
      SCAN_GARBAGE, SCAN_EQ, SCAN_BANG, SCAN_LT, SCAN_GT, SCAN_AMP, SCAN_BAR
   } scan_mode_type;

   typedef enum logic [2:0] {
      CH_OTHER, CH_DIGIT, CH_UPPER, CH_LOWER, CH_BLANK, CH_SYMBOL
   } char_class_type;

   // One input beat; typed rows carry their own expected tokens.
   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
      logic       typed;
      logic [1:0] count;
      logic [5:0] first;
      logic [5:0] second;
   } lex_row_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;   // end_of_input
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [5:0] token_code, [7:6] zero
   logic       rsp_tlast;   // last_of_run

   core_language_lexer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   string keyword_text [1:11] = '{"program", "begin", "end", "int", "if", "then",
                                  "else", "while", "loop", "read", "write"};
   string symbol_text [19] = '{";", ",", "=", "==", "!", "!=", "<", "<=", ">", ">=",
                               "[", "]", "&&", "||", "(", ")", "+", "-", "*"};

   // Scanner copy kept by the bench
   scan_mode_type lex_mode;
   logic [5:0] kw_code;
   int         kw_pos;
   logic [5:0] step_codes [2];
   int         step_count;

   token_type  pending_tokens [$];
   lex_row_type directed_rows [26];
   lex_row_type byte_stream [$];
   bit         token_seen [64];
   int         error_count;
   int         beats_sent;
   int         useful_items;
   int         end_markers;
   int         tokens_checked;
   int         tx_calm_left;
   int         rx_calm_left;
   bit         hold_off_request;

   function automatic char_class_type classify(logic [7:0] b);
      if (b >= "0" && b <= "9") return CH_DIGIT;
      if (b >= "A" && b <= "Z") return CH_UPPER;
      if (b >= "a" && b <= "z") return CH_LOWER;
      if (b == " " || b == "\t" || b == "\n") return CH_BLANK;
      if (b == "!" || (b >= "(" && b <= "-") || (b >= ";" && b <= ">") ||
          b == "[" || b == "]" || b == "|") return CH_SYMBOL;
      return CH_OTHER;
   endfunction

   function automatic bit is_delimiter(logic [7:0] b);
      return classify(b) == CH_BLANK || classify(b) == CH_SYMBOL;
   endfunction

   function automatic void emit_token(logic [5:0] code);
      if (step_count < 2) begin
         step_codes[step_count] = code;
         step_count++;
      end
   endfunction

   function automatic void go_idle();
      lex_mode = SCAN_IDLE;
      kw_code  = TOK_ERROR;
      kw_pos   = 0;
   endfunction

   // Swallow bytes until a blank closes the run.
   function automatic void feed_garbage(logic [7:0] b);
      lex_mode = SCAN_GARBAGE;
      if (classify(b) == CH_BLANK) begin
         emit_token(TOK_ERROR);
         go_idle();
      end
   endfunction

   function automatic void open_token(logic [7:0] b);
      go_idle();
      if (b <= 8'd32 || b >= 8'd128) return;
      case (b)
         "p": kw_code = TOK_PROGRAM;
         "b": kw_code = TOK_BEGIN;
         "e": kw_code = TOK_END;
         "i": kw_code = TOK_IF;
         "t": kw_code = TOK_THEN;
         "w": kw_code = TOK_WHILE;
         "l": kw_code = TOK_LOOP;
         "r": kw_code = TOK_READ;
         ";": begin emit_token(TOK_SEMI); return; end
         ",": begin emit_token(TOK_COMMA); return; end
         "[": begin emit_token(TOK_LBRACKET); return; end
         "]": begin emit_token(TOK_RBRACKET); return; end
         "(": begin emit_token(TOK_LPAREN); return; end
         ")": begin emit_token(TOK_RPAREN); return; end
         "+": begin emit_token(TOK_PLUS); return; end
         "-": begin emit_token(TOK_MINUS); return; end
         "*": begin emit_token(TOK_TIMES); return; end
         "=": begin lex_mode = SCAN_EQ; return; end
         "!": begin lex_mode = SCAN_BANG; return; end
         "<": begin lex_mode = SCAN_LT; return; end
         ">": begin lex_mode = SCAN_GT; return; end
         "&": begin lex_mode = SCAN_AMP; return; end
         "|": begin lex_mode = SCAN_BAR; return; end
         default: ;
      endcase
      if (kw_code != TOK_ERROR) begin
         lex_mode = SCAN_KEYWORD;
         kw_pos   = 1;
      end else if (classify(b) == CH_UPPER) begin
         lex_mode = SCAN_ID_LETTERS;
      end else if (classify(b) == CH_DIGIT) begin
         lex_mode = SCAN_INTEGER;
      end else begin
         lex_mode = SCAN_GARBAGE;
      end
   endfunction

   function automatic void advance_keyword(logic [7:0] b);
      string text;
      int    len;
      text = keyword_text[kw_code];
      len  = text.len();
      if (kw_pos < len && text[kw_pos] == b) begin
         kw_pos++;
         return;
      end
      // Shared first letters: e -> else, i -> int, w -> write
      if (kw_pos == 1) begin
         if (kw_code == TOK_END && b == "l") begin
            kw_code = TOK_ELSE;
            kw_pos  = 2;
            return;
         end
         if (kw_code == TOK_IF && b == "n") begin
            kw_code = TOK_INT;
            kw_pos  = 2;
            return;
         end
         if (kw_code == TOK_WHILE && b == "r") begin
            kw_code = TOK_WRITE;
            kw_pos  = 2;
            return;
         end
      end
      if (kw_pos == len && is_delimiter(b)) begin
         emit_token(kw_code);
         open_token(b);
         return;
      end
      feed_garbage(b);
   endfunction

   function automatic void finish_word(logic [7:0] b, logic [5:0] code);
      if (is_delimiter(b)) begin
         emit_token(code);
         open_token(b);
      end else begin
         feed_garbage(b);
      end
   endfunction

   function automatic void resolve_pair(logic [7:0] b, logic [5:0] single,
                                        logic [5:0] pair);
      if (b == "=") begin
         emit_token(pair);
         go_idle();
      end else begin
         emit_token(single);
         open_token(b);
      end
   endfunction

   function automatic void scan_byte(logic [7:0] b, logic eoi);
      char_class_type cls;
      cls = classify(b);
      step_count = 0;
      if (eoi) begin
         // Flush a pending token, then mark the end.
         case (lex_mode)
            SCAN_IDLE: ;
            SCAN_EQ:   emit_token(TOK_ASSIGN);
            SCAN_BANG: emit_token(TOK_NOT);
            SCAN_LT:   emit_token(TOK_LESS);
            SCAN_GT:   emit_token(TOK_GREATER);
            default:   emit_token(TOK_ERROR);
         endcase
         emit_token(TOK_EOF);
         go_idle();
         return;
      end
      case (lex_mode)
         SCAN_KEYWORD: advance_keyword(b);
         SCAN_ID_LETTERS: begin
            if (cls == CH_DIGIT) lex_mode = SCAN_ID_DIGITS;
            else if (cls != CH_UPPER) finish_word(b, TOK_IDENT);
         end
         SCAN_ID_DIGITS: begin
            if (cls != CH_DIGIT) finish_word(b, TOK_IDENT);
         end
         SCAN_INTEGER: begin
            if (cls != CH_DIGIT) finish_word(b, TOK_INTEGER);
         end
         SCAN_GARBAGE: feed_garbage(b);
         SCAN_EQ:      resolve_pair(b, TOK_ASSIGN, TOK_EQUAL);
         SCAN_BANG:    resolve_pair(b, TOK_NOT, TOK_NOT_EQUAL);
         SCAN_LT:      resolve_pair(b, TOK_LESS, TOK_LESS_EQ);
         SCAN_GT:      resolve_pair(b, TOK_GREATER, TOK_GREATER_EQ);
         // The byte after & or | is taken whatever it is, blanks too.
         SCAN_AMP: begin
            if (b == "&") begin
               emit_token(TOK_AND);
               go_idle();
            end else begin
               lex_mode = SCAN_GARBAGE;
            end
         end
         SCAN_BAR: begin
            if (b == "|") begin
               emit_token(TOK_OR);
               go_idle();
            end else begin
               lex_mode = SCAN_GARBAGE;
            end
         end
         default: open_token(b);
      endcase
   endfunction

   function automatic void store_expected(lex_row_type row);
      token_type tok;
      logic      was_idle;
      was_idle = lex_mode == SCAN_IDLE;
      scan_byte(row.data, row.eoi);
      if (row.typed) begin
         step_count    = row.count;
         step_codes[0] = row.first;
         step_codes[1] = row.second;
      end
      for (int i = 0; i < step_count; i++) begin
         tok.code = step_codes[i];
         tok.last = (i == step_count - 1);
         pending_tokens.push_back(tok);
      end
      beats_sent++;
      if (row.eoi) end_markers++;
      // Bytes skipped between tokens are not counted as scanned.
      if (row.eoi || !was_idle || lex_mode != SCAN_IDLE || step_count != 0)
         useful_items++;
   endfunction

   // Mostly short gaps, some long, with idle-free stretches now and then.
   function automatic int pick_idle(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(20, 60);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_byte(logic [7:0] b);
      byte_stream.push_back('{b, 1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR});
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 2))
         0: return " ";
         1: return "\t";
         default: return "\n";
      endcase
   endfunction

   // Append one source fragment: mostly well-formed tokens, some noise.
   function automatic void queue_segment();
      int    kind;
      int    cut;
      bit    word;
      string text;
      kind = $urandom_range(0, 99);
      word = 1'b0;
      if (kind < 18) begin
         push_text(keyword_text[$urandom_range(1, 11)]);
         word = 1'b1;
      end else if (kind < 28) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(65, 90)));
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(48, 57)));
         word = 1'b1;
      end else if (kind < 38) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(48, 57)));
         word = 1'b1;
      end else if (kind < 58) begin
         push_text(symbol_text[$urandom_range(0, 18)]);
      end else if (kind < 78) begin
         repeat ($urandom_range(1, 3)) push_byte(blank_byte());
         if ($urandom_range(0, 4) == 0)
            push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 32))
                                           : 8'($urandom_range(128, 255)));
      end else if (kind < 86) begin
         // Keyword prefix broken by an arbitrary byte
         text = keyword_text[$urandom_range(1, 11)];
         cut  = $urandom_range(1, text.len());
         for (int i = 0; i < cut; i++) push_byte(text[i]);
         push_byte(8'($urandom));
         word = 1'b1;
      end else if (kind < 94) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else if (kind < 97) begin
         push_byte($urandom_range(0, 1) ? "&" : "|");
         push_byte(8'($urandom));
      end else begin
         byte_stream.push_back('{8'($urandom), 1'b1, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR});
      end
      if (word && $urandom_range(0, 3) != 0) push_byte(blank_byte());
   endfunction

   // Offer one beat from a falling edge, hold until taken, then maybe idle.
   task automatic send_beat(input lex_row_type row);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.eoi;
      do @(posedge clock); while (!req_tready);
      store_expected(row);
      @(negedge clock);
      gap = hold_off_request ? 0 : pick_idle(tx_calm_left);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** core_language_lexer_unit: FAILED **");
      $finish;
   end

   // Token sink: random stalls, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_idle(rx_calm_left);
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tokens_checked++;
         token_seen[rsp_tdata[5:0]] = 1'b1;
         if (pending_tokens.size() == 0) begin
            $error("unexpected token beat: token_code %0d", rsp_tdata[5:0]);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_tdata[5:0] !== want.code) begin
               $error("token_code: expected %0d, got %0d", want.code, rsp_tdata[5:0]);
               error_count++;
            end
            if (rsp_tdata[7:6] !== 2'b00) begin
               $error("tdata pad: expected 0, got %0d", rsp_tdata[7:6]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      int  codes_hit;
      bit  hold_done;
      bit  drain_done;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      go_idle();
      // data, end, typed, count, first, second
      directed_rows = '{
         '{8'h00, 1'b0, 1'b1, 2'd0, TOK_ERROR, TOK_ERROR},
         '{8'hFF, 1'b0, 1'b1, 2'd0, TOK_ERROR, TOK_ERROR},
         '{";",   1'b0, 1'b1, 2'd1, TOK_SEMI, TOK_ERROR},
         '{"=",   1'b0, 1'b1, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"=",   1'b0, 1'b1, 2'd1, TOK_EQUAL, TOK_ERROR},
         '{"<",   1'b0, 1'b1, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"A",   1'b0, 1'b1, 2'd1, TOK_LESS, TOK_ERROR},
         '{"7",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{" ",   1'b0, 1'b1, 2'd1, TOK_IDENT, TOK_ERROR},
         '{"i",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"n",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"t",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"(",   1'b0, 1'b1, 2'd2, TOK_INT, TOK_LPAREN},
         '{"&",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"&",   1'b0, 1'b1, 2'd1, TOK_AND, TOK_ERROR},
         '{"|",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{" ",   1'b0, 1'b1, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"\t",  1'b0, 1'b1, 2'd1, TOK_ERROR, TOK_ERROR},
         '{"#",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"\n",  1'b0, 1'b1, 2'd1, TOK_ERROR, TOK_ERROR},
         '{"e",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{"q",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{" ",   1'b0, 1'b1, 2'd1, TOK_ERROR, TOK_ERROR},
         '{">",   1'b0, 1'b0, 2'd0, TOK_ERROR, TOK_ERROR},
         '{8'hFF, 1'b1, 1'b1, 2'd2, TOK_GREATER, TOK_EOF},
         '{8'h00, 1'b1, 1'b1, 2'd1, TOK_EOF, TOK_ERROR}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_beat(directed_rows[i]);

      while (beats_sent < ITEM_TARGET) begin
         if (!hold_done && useful_items >= HOLD_OFF_AT) begin
            hold_off_request = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && useful_items >= DRAIN_AT) begin
            // Pause the source until every token is out.
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_tokens.size() != 0);
            drain_done = 1'b1;
         end
         if (byte_stream.size() == 0) queue_segment();
         send_beat(byte_stream.pop_front());
      end
      req_tvalid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      codes_hit = 0;
      for (int c = 0; c <= 33; c++) codes_hit += token_seen[c];
      $display("lexer run: %0d beats sent (%0d scanned, %0d end markers), %0d tokens checked",
               beats_sent, useful_items, end_markers, tokens_checked);
      $display("lexer run: %0d of 34 token codes seen, output hold-off and source drain done",
               codes_hit);
      if (error_count == 0) begin
         $display("** core_language_lexer_unit: PASSED **");
      end else begin
         $display("** core_language_lexer_unit: FAILED **");
      end
      $finish;
   end

endmodule
